FILE: sv/depth_to_space_reorder_unit_defines.svh
// Assertion macros for the depth-to-space reorder unit checker
`ifndef DEPTH_TO_SPACE_REORDER_UNIT_DEFINES_SVH
`define DEPTH_TO_SPACE_REORDER_UNIT_DEFINES_SVH

// checked only while out of reset
`define D2S_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define D2S_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/d2s_pkg.sv
// Shared types and constants of the depth-to-space reorder unit
package d2s_pkg;

    localparam int CFG_DW = 14;
    localparam int CFG_IW = 2;

    typedef logic [CFG_IW-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_BLOCK_SIZE  = 2'd0;
    localparam t_cfg_idx CFG_IN_WIDTH    = 2'd1;
    localparam t_cfg_idx CFG_IN_CHANNELS = 2'd2;

    localparam logic [2:0]  RST_BLOCK_SIZE  = 3'd3;
    localparam logic [13:0] RST_IN_WIDTH    = 14'd648;
    localparam logic [6:0]  RST_IN_CHANNELS = 7'd9;

    localparam logic [6:0] CH_MAX = 7'd64;

    typedef enum logic [3:0] {
        SEQ_START,
        SEQ_DIV_W,
        SEQ_DIV_N,
        SEQ_MUL_A,
        SEQ_MUL_B,
        SEQ_MUL_C,
        SEQ_DIV_R,
        SEQ_WALK,
        SEQ_RUN
    } t_seq_state;

    typedef enum logic [1:0] {
        DIV_WLIM,
        DIV_NEWC,
        DIV_ROWPOS
    } t_div_sel;

    typedef struct packed {
        logic     div_start;
        t_div_sel div_sel;
        logic     ld_geom;
        logic     ld_w;
        logic     ld_newc;
        logic     ld_prod;
        logic     ld_rowout;
        logic     ld_total;
        logic     ld_rowpos;
        logic     walk_step;
        logic     run;
    } t_seq_ctl;

endpackage

FILE: sv/d2s_in_if.sv
// Input stream interface: valid/ready with mode and input element
interface d2s_in_if #(
    parameter int DATA_WIDTH = 16
) ();
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic signed [DATA_WIDTH-1:0] in_data;

    modport source (output valid, output mode, output in_data, input ready);
    modport sink   (input valid, input mode, input in_data, output ready);
endinterface

FILE: sv/d2s_out_if.sv
// Output stream interface: valid/ready with output element and row end flag
interface d2s_out_if #(
    parameter int DATA_WIDTH = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] out_data;
    logic                         row_end;

    modport source (output valid, output out_data, output row_end, input ready);
    modport sink   (input valid, input out_data, input row_end, output ready);
endinterface

FILE: sv/d2s_ram.sv
// Generic simple dual-port RAM with registered read
module d2s_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/d2s_div.sv
// Iterative restoring divider, one quotient bit per cycle
module d2s_div #(
    parameter int W = 17
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quot,
    output logic [W-1:0] o_rem
);
    localparam int CNTW = $clog2(W + 1);

    logic [CNTW-1:0] r_cnt;
    logic            r_done;
    logic [W-1:0]    r_rem;
    logic [W-1:0]    r_quot;
    logic [W-1:0]    r_dvs;
    logic [W:0]      trial;

    assign trial = {r_rem, r_quot[W-1]} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNTW'(W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_cnt != '0) begin
            if (!trial[W]) begin
                r_rem  <= trial[W-1:0];
                r_quot <= {r_quot[W-2:0], 1'b1};
            end else begin
                r_rem  <= {r_rem[W-2:0], r_quot[W-1]};
                r_quot <= {r_quot[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

FILE: sv/depth_to_space_reorder_unit.sv
// Depth-to-space reorder unit: ping-pong row store with output-order writes
//
//  channel | dir | handshake     | payload
//  i_in    | in  | valid/ready   | mode, in_data
//  o_out   | out | valid/ready   | out_data, row_end
//  i_cfg   | in  | write enable  | i_cfg_idx, i_cfg_data
//
// One item per cycle unless input is stalled; the row store takes one write and one read per cycle.
// A result leaves the store read register in the cycle after its item and
// enters a three-entry output queue; input stalls once three results wait
// behind a blocked o_out.
// After reset and after each register write, a setup sequencer (three
// divisions of max(RW,7) bits at one bit per cycle, three multiply steps, then
// one walk step per current channel count) holds input off,
// RW = clog2(ROW_ELEMS_MAX+1).
// Reset is synchronous; the row store is not cleared.
module depth_to_space_reorder_unit
    import d2s_pkg::*;
#(
    parameter int ROW_ELEMS_MAX = 8192,
    parameter int DATA_WIDTH    = 16,
    parameter int BLOCK_MAX     = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  t_cfg_idx          i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    d2s_in_if.sink            i_in,
    d2s_out_if.source         o_out
);
    localparam int RW   = $clog2(ROW_ELEMS_MAX + 1);
    localparam int COLW = $clog2(ROW_ELEMS_MAX);
    localparam int OW   = RW + 7;
    localparam int BW   = $clog2(BLOCK_MAX + 1);
    localparam int JW   = $clog2(BLOCK_MAX);
    localparam int QW   = (RW > 7) ? RW : 7;
    localparam int CW   = (RW > 14) ? RW : 14;
    localparam int MAW  = $clog2(2 * ROW_ELEMS_MAX);
    localparam int FIFO_DEPTH = 3;
    localparam int FPW  = $clog2(FIFO_DEPTH);
    localparam int FCW  = $clog2(FIFO_DEPTH + 1);
    localparam logic [MAW-1:0] BANK_OFS = MAW'(ROW_ELEMS_MAX);

    typedef struct packed {
        logic [5:0]    k;
        logic [JW-1:0] j;
        logic [5:0]    i;
        logic [OW-1:0] off;
        logic [OW-1:0] jbase;
        logic [OW-1:0] ibase;
    } t_sub;

    function automatic t_sub adv(t_sub s, logic [6:0] newc, logic [BW-1:0] b,
                                 logic [RW-1:0] row_out);
        t_sub r;
        r = s;
        if ((7'(s.k) + 7'd1) >= newc) begin
            r.k = '0;
            if ((BW'(s.j) + BW'(1)) >= b) begin
                r.j     = '0;
                r.i     = s.i + 6'd1;
                r.ibase = s.ibase + OW'(row_out);
                r.jbase = r.ibase;
                r.off   = r.ibase;
            end else begin
                r.j     = s.j + JW'(1);
                r.jbase = s.jbase + OW'(newc);
                r.off   = r.jbase;
            end
        end else begin
            r.k   = s.k + 6'd1;
            r.off = s.off + OW'(1);
        end
        return r;
    endfunction

    // configuration
    logic [2:0]  r_cfg_b;
    logic [13:0] r_cfg_w;
    logic [6:0]  r_cfg_c;
    logic        cfg_hit;

    // geometry
    logic [BW-1:0]   r_b;
    logic [2*BW-1:0] r_bb;
    logic [6:0]      r_c;
    logic [CW-1:0]   r_w0;
    logic [RW-1:0]   r_w;
    logic [6:0]      r_newc;
    logic [BW+6:0]   r_bn;
    logic [6:0]      r_cmax;
    logic [RW-1:0]   r_row_out;
    logic [RW-1:0]   r_total;
    logic [BW-1:0]   clamp_b;
    logic [6:0]      clamp_c;
    logic [CW-1:0]   clamp_w0;

    // sequencer and divider
    t_seq_state r_state, n_state;
    t_seq_ctl   ctl;
    logic       div_done;
    logic [QW-1:0] div_quot, div_rem, div_dividend, div_divisor;
    logic [5:0] r_walk;

    // stream state
    logic [5:0]      r_chan, n_chan;
    logic [COLW-1:0] r_col, n_col;
    logic            r_bank, n_bank;
    logic [RW-1:0]   r_rp, n_rp;
    logic [RW-1:0]   r_rowpos, n_rowpos;
    logic            r_active, n_active;
    logic [OW-1:0]   r_pix_base, n_pix_base;
    t_sub            r_sub, n_sub;

    // datapath
    logic            acc, rd_ok, emit, row_last, wr_en, chan_wrap, col_wrap;
    logic [RW-1:0]   rp_inc;
    logic [OW:0]     wr_addr_full;
    logic [MAW-1:0]  wr_addr, rd_addr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic            r_s1_vld, r_s1_end;

    // output queue
    logic [DATA_WIDTH-1:0] r_fdata [FIFO_DEPTH];
    logic                  r_fend  [FIFO_DEPTH];
    logic [FPW-1:0]        r_fwp, r_frp;
    logic [FCW-1:0]        r_fcnt;
    logic                  push, pop;

    function automatic logic [FPW-1:0] ptr_next(logic [FPW-1:0] p);
        return (p == FPW'(FIFO_DEPTH - 1)) ? '0 : p + FPW'(1);
    endfunction

    assign cfg_hit = i_cfg_we && (i_cfg_idx == CFG_BLOCK_SIZE ||
                                  i_cfg_idx == CFG_IN_WIDTH ||
                                  i_cfg_idx == CFG_IN_CHANNELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_b <= RST_BLOCK_SIZE;
            r_cfg_w <= RST_IN_WIDTH;
            r_cfg_c <= RST_IN_CHANNELS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BLOCK_SIZE:  r_cfg_b <= i_cfg_data[2:0];
                CFG_IN_WIDTH:    r_cfg_w <= i_cfg_data[13:0];
                CFG_IN_CHANNELS: r_cfg_c <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_b == 3'd0) begin
            clamp_b = BW'(1);
        end else if (4'(r_cfg_b) > 4'(BLOCK_MAX)) begin
            clamp_b = BW'(BLOCK_MAX);
        end else begin
            clamp_b = BW'(r_cfg_b);
        end
        if (r_cfg_c == 7'd0) begin
            clamp_c = 7'd1;
        end else if (r_cfg_c > CH_MAX) begin
            clamp_c = CH_MAX;
        end else begin
            clamp_c = r_cfg_c;
        end
        clamp_w0 = (r_cfg_w == 14'd0) ? CW'(1) : CW'(r_cfg_w);
    end

    // setup sequencer
    always_comb begin
        n_state = r_state;
        if (cfg_hit) begin
            n_state = SEQ_START;
        end else begin
            unique case (r_state)
                SEQ_START: n_state = SEQ_DIV_W;
                SEQ_DIV_W: if (div_done) n_state = SEQ_DIV_N;
                SEQ_DIV_N: if (div_done) n_state = SEQ_MUL_A;
                SEQ_MUL_A: n_state = SEQ_MUL_B;
                SEQ_MUL_B: n_state = SEQ_MUL_C;
                SEQ_MUL_C: n_state = SEQ_DIV_R;
                SEQ_DIV_R: if (div_done) n_state = SEQ_WALK;
                SEQ_WALK:  if (r_walk == r_chan) n_state = SEQ_RUN;
                SEQ_RUN:   n_state = SEQ_RUN;
                default:   n_state = SEQ_START;
            endcase
        end
    end

    always_comb begin
        ctl = '0;
        ctl.div_sel = DIV_WLIM;
        unique case (r_state)
            SEQ_START: begin
                ctl.ld_geom   = 1'b1;
                ctl.div_start = 1'b1;
                ctl.div_sel   = DIV_WLIM;
            end
            SEQ_DIV_W: begin
                ctl.ld_w      = div_done;
                ctl.div_start = div_done;
                ctl.div_sel   = DIV_NEWC;
            end
            SEQ_DIV_N: ctl.ld_newc = div_done;
            SEQ_MUL_A: ctl.ld_prod = 1'b1;
            SEQ_MUL_B: ctl.ld_rowout = 1'b1;
            SEQ_MUL_C: begin
                ctl.ld_total  = 1'b1;
                ctl.div_start = 1'b1;
                ctl.div_sel   = DIV_ROWPOS;
            end
            SEQ_DIV_R: ctl.ld_rowpos = div_done;
            SEQ_WALK:  ctl.walk_step = (r_walk != r_chan);
            SEQ_RUN:   ctl.run = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_START;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        unique case (ctl.div_sel)
            DIV_WLIM: begin
                div_dividend = QW'(ROW_ELEMS_MAX);
                div_divisor  = QW'(clamp_c);
            end
            DIV_NEWC: begin
                div_dividend = QW'(r_c);
                div_divisor  = QW'(r_bb);
            end
            DIV_ROWPOS: begin
                div_dividend = QW'(r_rp);
                div_divisor  = QW'(r_row_out);
            end
            default: begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    d2s_div #(.W(QW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctl.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (ctl.ld_geom) begin
            r_b  <= clamp_b;
            r_c  <= clamp_c;
            r_w0 <= clamp_w0;
            r_bb <= (2*BW)'(clamp_b * clamp_b);
        end
        if (ctl.ld_w) begin
            r_w <= (CW'(div_quot) < r_w0) ? RW'(div_quot) : RW'(r_w0);
        end
        if (ctl.ld_newc) begin
            r_newc <= 7'(div_quot);
        end
        if (ctl.ld_prod) begin
            r_bn   <= (BW+7)'(r_b * r_newc);
            r_cmax <= 7'(r_bb * r_newc);
        end
        if (ctl.ld_rowout) begin
            r_row_out <= RW'(r_w * r_bn);
        end
        if (ctl.ld_total) begin
            r_total <= RW'(r_row_out * r_b);
        end
        if (ctl.ld_rowpos) begin
            r_walk <= '0;
        end else if (ctl.walk_step) begin
            r_walk <= r_walk + 6'd1;
        end
    end

    // item datapath
    assign i_in.ready = ctl.run &&
                        ((FCW+1)'(r_fcnt) + (FCW+1)'(r_s1_vld) < (FCW+1)'(FIFO_DEPTH));
    assign acc       = i_in.valid && i_in.ready;
    assign rd_ok     = r_active && (r_rp < r_total) && (r_rp < RW'(ROW_ELEMS_MAX));
    assign emit      = acc && rd_ok;
    assign rp_inc    = r_rp + RW'(1);
    assign row_last  = (r_rowpos == r_row_out - RW'(1));
    assign chan_wrap = (7'(r_chan) + 7'd1) >= r_c;
    assign col_wrap  = (RW'(r_col) + RW'(1)) >= r_w;

    assign wr_addr_full = (OW+1)'(r_pix_base) + (OW+1)'(r_sub.off);
    assign wr_en = acc && !i_in.mode && (r_newc != 7'd0) && (7'(r_chan) < r_cmax) &&
                   (RW'(r_col) < r_w) && (wr_addr_full < (OW+1)'(ROW_ELEMS_MAX));
    assign wr_addr = (r_bank ? BANK_OFS : '0) + MAW'(wr_addr_full);
    assign rd_addr = (r_bank ? '0 : BANK_OFS) + MAW'(r_rp);

    always_comb begin
        n_rp       = r_rp;
        n_rowpos   = r_rowpos;
        n_active   = r_active;
        n_chan     = r_chan;
        n_col      = r_col;
        n_bank     = r_bank;
        n_pix_base = r_pix_base;
        n_sub      = r_sub;
        if (acc) begin
            if (r_active) begin
                if (rd_ok) begin
                    n_rp     = rp_inc;
                    n_rowpos = row_last ? '0 : r_rowpos + RW'(1);
                    if (rp_inc >= r_total) begin
                        n_active = 1'b0;
                    end
                end else begin
                    n_active = 1'b0;
                end
            end
            if (!i_in.mode) begin
                if (chan_wrap) begin
                    n_chan = '0;
                    n_sub  = '0;
                    if (col_wrap) begin
                        n_col      = '0;
                        n_pix_base = '0;
                        n_bank     = ~r_bank;
                        n_rp       = '0;
                        n_rowpos   = '0;
                        n_active   = (r_total != '0);
                    end else begin
                        n_col      = r_col + COLW'(1);
                        n_pix_base = r_pix_base + OW'(r_bn);
                    end
                end else begin
                    n_chan = r_chan + 6'd1;
                    n_sub  = adv(r_sub, r_newc, r_b, r_row_out);
                end
            end
        end
        if (ctl.ld_rowout) begin
            n_pix_base = OW'(r_col * r_bn);
        end
        if (ctl.ld_rowpos) begin
            n_rowpos = RW'(div_rem);
            n_sub    = '0;
        end else if (ctl.walk_step) begin
            n_sub = adv(r_sub, r_newc, r_b, r_row_out);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp     <= '0;
            r_rowpos <= '0;
            r_active <= 1'b0;
            r_chan   <= '0;
            r_col    <= '0;
            r_bank   <= 1'b0;
            r_s1_vld <= 1'b0;
        end else begin
            r_rp     <= n_rp;
            r_rowpos <= n_rowpos;
            r_active <= n_active;
            r_chan   <= n_chan;
            r_col    <= n_col;
            r_bank   <= n_bank;
            r_s1_vld <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix_base <= n_pix_base;
        r_sub      <= n_sub;
        if (emit) begin
            r_s1_end <= row_last;
        end
    end

    d2s_ram #(.WIDTH(DATA_WIDTH), .DEPTH(2 * ROW_ELEMS_MAX)) u_row_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_in.in_data),
        .i_re    (emit),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // output queue
    assign push = r_s1_vld;
    assign pop  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fdata[r_fwp] <= ram_rdata;
            r_fend[r_fwp]  <= r_s1_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwp  <= '0;
            r_frp  <= '0;
            r_fcnt <= '0;
        end else begin
            if (push) begin
                r_fwp <= ptr_next(r_fwp);
            end
            if (pop) begin
                r_frp <= ptr_next(r_frp);
            end
            unique case ({push, pop})
                2'b10:   r_fcnt <= r_fcnt + FCW'(1);
                2'b01:   r_fcnt <= r_fcnt - FCW'(1);
                default: r_fcnt <= r_fcnt;
            endcase
        end
    end

    assign o_out.valid    = (r_fcnt != '0);
    assign o_out.out_data = r_fdata[r_frp];
    assign o_out.row_end  = r_fend[r_frp];
endmodule

FILE: sv/d2s_chk.sv
// Port-level checker for the depth-to-space reorder unit, bound to the top
`include "depth_to_space_reorder_unit_defines.svh"

module d2s_chk
    import d2s_pkg::*;
#(
    parameter int DATA_WIDTH = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input t_cfg_idx              i_cfg_idx,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [DATA_WIDTH-1:0] i_out_data,
    input logic                  i_out_row_end
);
    logic [31:0] r_in_cnt;
    logic [31:0] r_out_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                r_in_cnt <= r_in_cnt + 32'd1;
            end
            if (i_out_valid && i_out_ready) begin
                r_out_cnt <= r_out_cnt + 32'd1;
            end
        end
    end

    `D2S_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data) && $stable(i_out_row_end), "stalled item changed")
    `D2S_ASSERT(a_out_after_in, i_out_valid |-> (r_out_cnt < r_in_cnt), "more results than items")
    `D2S_ASSERT(a_cfg_stalls_in, i_cfg_we && (i_cfg_idx == CFG_BLOCK_SIZE || i_cfg_idx == CFG_IN_WIDTH || i_cfg_idx == CFG_IN_CHANNELS) |=> !i_in_ready, "input taken during setup")
    `D2S_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !i_out_valid, "result after reset")
endmodule

bind depth_to_space_reorder_unit d2s_chk #(.DATA_WIDTH(DATA_WIDTH)) u_d2s_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_idx     (i_cfg_idx),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_data    (o_out.out_data),
    .i_out_row_end (o_out.row_end)
);
